/* sv/vmf_pkg.sv */
`timescale 1ns / 1ps

package vmf_pkg;

  // Model dimensions
  localparam int DIM         = 4;
  localparam int LAGS        = 4;
  localparam int MAX_HORIZON = 16;

  // Store depths
  localparam int COEF_DEPTH = LAGS * DIM * DIM;
  localparam int HIST_DEPTH = LAGS * DIM;
  // One spare lag slot in the working ring takes the new predictions
  localparam int WORK_SLOTS = LAGS + 1;
  localparam int WORK_DEPTH = WORK_SLOTS * DIM;

  // Index and counter widths
  localparam int CA_W   = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;
  localparam int HA_W   = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int WA_W   = $clog2(WORK_DEPTH);
  localparam int SLOT_W = $clog2(WORK_SLOTS);
  localparam int LAG_W  = (LAGS > 1) ? $clog2(LAGS) : 1;
  localparam int SRC_W  = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int TGT_W  = (SRC_W > 2) ? SRC_W : 2;
  localparam int STEP_W = ($clog2(MAX_HORIZON) > 4) ? $clog2(MAX_HORIZON) : 4;
  localparam int CNT_W  = $clog2(HIST_DEPTH + 1);

  // Datapath widths
  localparam int DATA_W = 16;
  localparam int PROD_W = 2 * DATA_W;
  localparam int ACC_W  = 40;
  localparam int FRAC_SHIFT = 14;

  // Item kinds
  localparam logic [1:0] KIND_COEF = 2'd0;
  localparam logic [1:0] KIND_HIST = 2'd1;
  localparam logic [1:0] KIND_RUN  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COPY,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT
  } vmf_state_e;

endpackage

/* sv/vmf_in_if.sv */
`timescale 1ns / 1ps

interface vmf_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [1:0]         lag;
  logic [1:0]         src;
  logic [1:0]         target;
  logic signed [15:0] value;
  logic [4:0]         horizon;

  modport source (output valid, kind, lag, src, target, value, horizon, input ready);
  modport sink   (input valid, kind, lag, src, target, value, horizon, output ready);
endinterface

/* sv/vmf_out_if.sv */
`timescale 1ns / 1ps

interface vmf_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         step;
  logic [1:0]         component;
  logic signed [15:0] prediction;
  logic               saturated;
  logic               last;

  modport source (output valid, step, component, prediction, saturated, last, input ready);
  modport sink   (input valid, step, component, prediction, saturated, last, output ready);
endinterface

/* sv/var_multistep_forecast.sv */
// Write items (coefficient, history sample) are accepted while idle; ready is high in idle.
// A forecast first copies the history store into the working ring, then each result
// is summed on the single MAC: one memory read per cycle plus drain.
// Reset clears the coefficient and history stores to zero through valid bits, so there is no clearing pass.
`timescale 1ns / 1ps

module var_multistep_forecast
  import vmf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  vmf_in_if.sink    in_i,
  vmf_out_if.source out_o
);

  localparam logic signed [ACC_W:0] RND_HALF = (ACC_W + 1)'(8192);
  localparam logic signed [ACC_W:0] PRED_MAX = (ACC_W + 1)'(32767);
  localparam logic signed [ACC_W:0] PRED_MIN = -(ACC_W + 1)'(32768);

  // Control state
  vmf_state_e state_q, state_d;
  logic [LAG_W-1:0]  l_q, l_d;
  logic [SRC_W-1:0]  s_q, s_d;
  logic [TGT_W-1:0]  t_q, t_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [STEP_W-1:0] last_step_q, last_step_d;
  logic [SLOT_W-1:0] head_q, head_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              cp_vld_q, cp_vld_d;
  logic [HA_W-1:0]   cp_addr_q;
  logic              rd_vld_q, rd_vld_d;
  logic              prod_vld_q;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic [COEF_DEPTH-1:0] coef_vld_q;
  logic [HIST_DEPTH-1:0] hist_vld_q;
  logic              out_vld_q, out_vld_d;

  // Memories and read registers
  logic signed [DATA_W-1:0] coef_mem [COEF_DEPTH];
  logic signed [DATA_W-1:0] hist_mem [HIST_DEPTH];
  logic signed [DATA_W-1:0] work_mem [WORK_DEPTH];
  logic signed [DATA_W-1:0] coef_rd_q, hist_rd_q, work_rd_q;
  logic                     coef_vld_rd_q, hist_vld_rd_q;
  logic signed [PROD_W-1:0] prod_q;

  // Output payload
  logic [3:0]               out_step_q;
  logic [1:0]               out_comp_q;
  logic signed [DATA_W-1:0] out_pred_q;
  logic                     out_sat_q, out_last_q;

  // Combinational controls
  logic in_fire, out_free, emit_go, last_res;
  logic coef_we, hist_we, wk_we;
  logic [CA_W-1:0] coef_wa, coef_ra;
  logic [HA_W-1:0] hist_wa, hist_ra;
  logic [WA_W-1:0] wk_wa, wk_ra;
  logic signed [DATA_W-1:0] wk_wd;
  logic [SLOT_W-1:0] new_head;
  int unsigned rd_slot_sum, rd_slot;
  logic signed [DATA_W-1:0] coef_op;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [ACC_W:0] rnd, shr;
  logic signed [DATA_W-1:0] pred;
  logic pred_sat;

  // Handshakes
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_free   = !out_vld_q || out_o.ready;
  assign emit_go    = (state_q == ST_EMIT) && out_free;
  assign last_res   = (step_q == last_step_q) && (int'(t_q) == DIM - 1);

  // Decode write transactions
  assign coef_we = in_fire && (in_i.kind == KIND_COEF) && (int'(in_i.lag) < LAGS)
                   && (int'(in_i.src) < DIM) && (int'(in_i.target) < DIM);
  assign hist_we = in_fire && (in_i.kind == KIND_HIST) && (int'(in_i.lag) < LAGS)
                   && (int'(in_i.src) < DIM);
  assign coef_wa = CA_W'((int'(in_i.lag) * DIM + int'(in_i.src)) * DIM
                         + int'(in_i.target));
  assign hist_wa = HA_W'(int'(in_i.lag) * DIM + int'(in_i.src));

  // Read addresses: history sweep during copy, ring lookup during MAC
  assign hist_ra     = cnt_q[HA_W-1:0];
  assign coef_ra     = CA_W'((int'(l_q) * DIM + int'(s_q)) * DIM + int'(t_q));
  assign rd_slot_sum = int'(head_q) + int'(l_q);
  assign rd_slot     = (rd_slot_sum >= WORK_SLOTS) ? rd_slot_sum - WORK_SLOTS : rd_slot_sum;
  assign wk_ra       = WA_W'(rd_slot * DIM + int'(s_q));
  assign new_head    = (head_q == '0) ? SLOT_W'(LAGS) : head_q - 1'b1;

  // Working ring write: copy fill or prediction insert into the spare slot
  always_comb begin
    wk_we = 1'b0;
    wk_wa = WA_W'(cp_addr_q);
    wk_wd = hist_vld_rd_q ? hist_rd_q : '0;
    if (cp_vld_q) begin
      wk_we = 1'b1;
    end else if (emit_go) begin
      wk_we = 1'b1;
      wk_wa = WA_W'(int'(new_head) * DIM + int'(t_q));
      wk_wd = pred;
    end
  end

  // Multiply with unwritten coefficients reading as zero
  assign coef_op = coef_vld_rd_q ? coef_rd_q : '0;
  assign prod_d  = coef_op * work_rd_q;

  // Round half up to Q7.8 and saturate
  assign rnd = $signed({acc_q[ACC_W-1], acc_q}) + RND_HALF;
  assign shr = rnd >>> FRAC_SHIFT;
  always_comb begin
    pred_sat = 1'b0;
    pred     = shr[DATA_W-1:0];
    if (shr > PRED_MAX) begin
      pred_sat = 1'b1;
      pred     = PRED_MAX[DATA_W-1:0];
    end else if (shr < PRED_MIN) begin
      pred_sat = 1'b1;
      pred     = PRED_MIN[DATA_W-1:0];
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && (in_i.kind == KIND_RUN) && (in_i.horizon != '0)) begin
          state_d = ST_COPY;
        end
      end
      ST_COPY: begin
        if (int'(cnt_q) == HIST_DEPTH) begin
          state_d = ST_MAC;
        end
      end
      ST_MAC: begin
        if ((int'(l_q) == LAGS - 1) && (int'(s_q) == DIM - 1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_vld_q) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = last_res ? ST_IDLE : ST_MAC;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Counters, pipeline flags and accumulator
  always_comb begin
    l_d         = l_q;
    s_d         = s_q;
    t_d         = t_q;
    step_d      = step_q;
    last_step_d = last_step_q;
    head_d      = head_q;
    cnt_d       = cnt_q;
    cp_vld_d    = 1'b0;
    rd_vld_d    = 1'b0;
    acc_d       = prod_vld_q ? acc_q + ACC_W'(prod_q) : acc_q;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d  = '0;
        l_d    = '0;
        s_d    = '0;
        t_d    = '0;
        step_d = '0;
        head_d = '0;
        if (int'(in_i.horizon) > MAX_HORIZON) begin
          last_step_d = STEP_W'(MAX_HORIZON - 1);
        end else begin
          last_step_d = STEP_W'(int'(in_i.horizon) - 1);
        end
        if (!in_fire || (in_i.kind != KIND_RUN)) begin
          last_step_d = last_step_q;
        end
      end
      ST_COPY: begin
        if (int'(cnt_q) < HIST_DEPTH) begin
          cp_vld_d = 1'b1;
          cnt_d    = cnt_q + 1'b1;
        end
      end
      ST_MAC: begin
        rd_vld_d = 1'b1;
        if (int'(s_q) == DIM - 1) begin
          s_d = '0;
          l_d = (int'(l_q) == LAGS - 1) ? '0 : l_q + 1'b1;
        end else begin
          s_d = s_q + 1'b1;
        end
      end
      ST_DRAIN: begin
      end
      ST_EMIT: begin
        if (out_free) begin
          acc_d = '0;
          if (int'(t_q) == DIM - 1) begin
            t_d    = '0;
            step_d = step_q + 1'b1;
            head_d = new_head;
          end else begin
            t_d = t_q + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Output register valid
  always_comb begin
    out_vld_d = out_vld_q;
    if (emit_go) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      l_q         <= '0;
      s_q         <= '0;
      t_q         <= '0;
      step_q      <= '0;
      last_step_q <= '0;
      head_q      <= '0;
      cnt_q       <= '0;
      cp_vld_q    <= 1'b0;
      rd_vld_q    <= 1'b0;
      prod_vld_q  <= 1'b0;
      acc_q       <= '0;
      coef_vld_q  <= '0;
      hist_vld_q  <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      l_q         <= l_d;
      s_q         <= s_d;
      t_q         <= t_d;
      step_q      <= step_d;
      last_step_q <= last_step_d;
      head_q      <= head_d;
      cnt_q       <= cnt_d;
      cp_vld_q    <= cp_vld_d;
      rd_vld_q    <= rd_vld_d;
      prod_vld_q  <= rd_vld_q;
      acc_q       <= acc_d;
      out_vld_q   <= out_vld_d;
      if (coef_we) begin
        coef_vld_q[coef_wa] <= 1'b1;
      end
      if (hist_we) begin
        hist_vld_q[hist_wa] <= 1'b1;
      end
    end
  end

  // Coefficient memory
  always_ff @(posedge clk_i) begin
    if (coef_we) begin
      coef_mem[coef_wa] <= in_i.value;
    end
    coef_rd_q     <= coef_mem[coef_ra];
    coef_vld_rd_q <= coef_vld_q[coef_ra];
  end

  // History memory
  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      hist_mem[hist_wa] <= in_i.value;
    end
    hist_rd_q     <= hist_mem[hist_ra];
    hist_vld_rd_q <= hist_vld_q[hist_ra];
  end

  // Working ring memory; predictions go to the spare slot, never read in the same step
  always_ff @(posedge clk_i) begin
    if (wk_we) begin
      work_mem[wk_wa] <= wk_wd;
    end
    work_rd_q <= work_mem[wk_ra];
  end

  // Datapath payload registers
  always_ff @(posedge clk_i) begin
    cp_addr_q <= hist_ra;
    prod_q    <= prod_d;
    if (emit_go) begin
      out_step_q <= step_q[3:0];
      out_comp_q <= t_q[1:0];
      out_pred_q <= pred;
      out_sat_q  <= pred_sat;
      out_last_q <= last_res;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.step       = out_step_q;
  assign out_o.component  = out_comp_q;
  assign out_o.prediction = out_pred_q;
  assign out_o.saturated  = out_sat_q;
  assign out_o.last       = out_last_q;

  // The sum is complete before a result is formed
  a_emit_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (!rd_vld_q && !prod_vld_q))
    else $error("result formed with products still in flight");

  // Ring writes never coincide with MAC reads
  a_no_write_in_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wk_we |-> (state_q != ST_MAC))
    else $error("working ring written during MAC issue");

  // Ring head stays within the slot count
  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(head_q) <= LAGS)
    else $error("ring head out of range");

  // A new transaction is taken only after the forecast has finished
  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_go && last_res) |=> (state_q == ST_IDLE))
    else $error("forecast did not return to idle after its last result");

endmodule
